// ===== design/bamsp_pkg.sv =====
// ---------------------------------------------------------------------------
// bamsp_pkg: shared constants for the advertising serial parser
// Byte codes, register map, phase codes and stream widths.
// ---------------------------------------------------------------------------
package bamsp_pkg;

    // Stream widths
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 72;
    localparam int unsigned BCD_W    = 64;
    localparam int unsigned CNT_W    = 5;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_COMPANY_ID = 1'b0;   // paddr[2]
    localparam logic [15:0] COMPANY_ID_RESET = 16'h09C8;

    // Serial limit
    localparam int unsigned MAX_DIGITS_DEF = 16;

    // Byte codes
    localparam logic [7:0] AD_TYPE_MFR = 8'hFF;
    localparam logic [7:0] CH_T        = 8'h54;
    localparam logic [7:0] CH_N        = 8'h4E;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    // Parse phase codes
    localparam logic [2:0] PH_LEN  = 3'd0;
    localparam logic [2:0] PH_TYPE = 3'd1;
    localparam logic [2:0] PH_CID0 = 3'd2;
    localparam logic [2:0] PH_CID1 = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_SKIP = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;

endpackage

// ===== design/ble_adv_mfr_serial_parser_core.sv =====
// ---------------------------------------------------------------------------
// ble_adv_mfr_serial_parser_core: manufacturer serial number scanner
// Walks advertising structures and extracts a "TN" serial as BCD.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: one advertising payload byte per request on i_s_tdata,
//   i_s_tlast high on the final byte of the payload.
//   Master stream: exactly one result request per payload, issued for the
//   byte marked i_s_tlast; nothing is issued for other bytes.
//   APB port: company_id at byte address 0; writes only while idle.
// Output: the result for a last byte is valid on o_m_tvalid in the cycle
//   after that byte is accepted.
// Throughput: one byte per cycle while o_s_tready is high. The per-byte parse step is a short
//   combinational update of the parse state registers; the result sits
//   in a single output register.
// Stall: while a result waits with i_m_tready low, o_s_tready drops and
//   every input byte is held off, last or not; a result taken in the same
//   cycle frees the register for the next one.
// Reset: clears the parse state and the output valid; company_id returns
//   to 0x09C8. Result payload registers are not reset.
// ---------------------------------------------------------------------------
module ble_adv_mfr_serial_parser_core #(
    parameter int unsigned MAX_DIGITS = bamsp_pkg::MAX_DIGITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [bamsp_pkg::S_DATA_W-1:0]      i_s_tdata,  // [7:0] payload_byte
    input  logic                                i_s_tlast,  // last_byte
    // master stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [0] found, [1] serial_started, [6:2] digit_count,
    // [70:7] serial_bcd, [71] digits_overflow
    output logic [bamsp_pkg::M_DATA_W-1:0]      o_m_tdata,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bamsp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bamsp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bamsp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    // Configuration register
    logic [15:0] r_company_id;

    // Parse state
    logic [2:0]                        r_phase,      n_phase;
    logic [7:0]                        r_bytes_left, n_bytes_left;
    logic                              r_cand,       n_cand;
    logic                              r_locked,     n_locked;
    logic                              r_pend_t,     n_pend_t;
    logic                              r_ser_on,     n_ser_on;
    logic                              r_ser_stop,   n_ser_stop;
    logic [bamsp_pkg::BCD_W-1:0]       r_store,      n_store;
    logic [bamsp_pkg::CNT_W-1:0]       r_digits_seen, n_digits_seen;
    logic                              r_ovf,        n_ovf;

    // Result register
    logic                              r_out_valid;
    logic [bamsp_pkg::M_DATA_W-1:0]    r_out_data;

    logic                              s_acc;
    logic                              m_acc;
    logic [7:0]                        b;
    logic [7:0]                        bl_dec;
    logic                              cid_hi_ok;
    logic                              is_digit;
    logic                              is_filler;
    logic                              ser_clear;
    logic [bamsp_pkg::M_DATA_W-1:0]    n_out_data;

    assign pready     = 1'b1;
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_acc      = r_out_valid && i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign b         = i_s_tdata;
    assign bl_dec    = r_bytes_left - 8'd1;
    assign cid_hi_ok = r_cand && (b == r_company_id[15:8]);
    assign is_digit  = (b inside {[bamsp_pkg::CH_ZERO:bamsp_pkg::CH_NINE]});
    assign is_filler = (b inside {bamsp_pkg::CH_SPACE, bamsp_pkg::CH_HASH,
                                  bamsp_pkg::CH_DASH});

    // APB: register write and read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_company_id <= bamsp_pkg::COMPANY_ID_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == bamsp_pkg::REG_COMPANY_ID) begin
            r_company_id <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == bamsp_pkg::REG_COMPANY_ID) begin
            prdata = {{(bamsp_pkg::APB_DATA_W-16){1'b0}}, r_company_id};
        end
    end

    // Per-byte parse step
    always_comb begin
        n_phase       = r_phase;
        n_bytes_left  = r_bytes_left;
        n_cand        = r_cand;
        n_locked      = r_locked;
        n_pend_t      = r_pend_t;
        n_ser_on      = r_ser_on;
        n_ser_stop    = r_ser_stop;
        n_store       = r_store;
        n_digits_seen = r_digits_seen;
        n_ovf         = r_ovf;
        ser_clear     = 1'b0;

        case (r_phase)
            bamsp_pkg::PH_LEN: begin
                // skip zero-length entries
                if (b != 8'd0) begin
                    n_bytes_left = b;
                    n_phase      = bamsp_pkg::PH_TYPE;
                end
            end
            bamsp_pkg::PH_TYPE: begin
                n_bytes_left = bl_dec;
                if (b == bamsp_pkg::AD_TYPE_MFR && bl_dec >= 8'd2) begin
                    n_cand  = 1'b1;
                    n_phase = bamsp_pkg::PH_CID0;
                end else begin
                    n_cand  = 1'b0;
                    n_phase = (bl_dec == 8'd0) ? bamsp_pkg::PH_LEN : bamsp_pkg::PH_SKIP;
                end
            end
            bamsp_pkg::PH_CID0: begin
                n_bytes_left = bl_dec;
                n_cand       = r_cand && (b == r_company_id[7:0]);
                n_phase      = bamsp_pkg::PH_CID1;
            end
            bamsp_pkg::PH_CID1: begin
                n_bytes_left = bl_dec;
                n_cand       = cid_hi_ok;
                if (cid_hi_ok) begin
                    ser_clear = 1'b1;
                    if (bl_dec == 8'd0) begin
                        n_locked = 1'b1;
                        n_phase  = bamsp_pkg::PH_DONE;
                    end else begin
                        n_phase  = bamsp_pkg::PH_DATA;
                    end
                end else begin
                    n_phase = (bl_dec == 8'd0) ? bamsp_pkg::PH_LEN : bamsp_pkg::PH_SKIP;
                end
            end
            bamsp_pkg::PH_DATA: begin
                n_bytes_left = bl_dec;
                if (!r_ser_stop) begin
                    if (!r_ser_on) begin
                        // hunt for the TN marker
                        if (r_pend_t && b == bamsp_pkg::CH_N) begin
                            n_ser_on = 1'b1;
                            n_pend_t = 1'b0;
                        end else begin
                            n_pend_t = (b == bamsp_pkg::CH_T);
                        end
                    end else if (is_digit) begin
                        if (r_digits_seen < bamsp_pkg::CNT_W'(MAX_DIGITS)) begin
                            n_store       = {r_store[bamsp_pkg::BCD_W-5:0], b[3:0]};
                            n_digits_seen = r_digits_seen + bamsp_pkg::CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (!is_filler) begin
                        n_ser_stop = 1'b1;
                    end
                end
                if (bl_dec == 8'd0) begin
                    n_locked = 1'b1;
                    n_phase  = bamsp_pkg::PH_DONE;
                end
            end
            bamsp_pkg::PH_SKIP: begin
                n_bytes_left = bl_dec;
                if (bl_dec == 8'd0) begin
                    n_phase = bamsp_pkg::PH_LEN;
                end
            end
            default: begin
                // done: ignore the rest of the payload
            end
        endcase

        // restart serial capture on a fresh match
        if (ser_clear) begin
            n_pend_t      = 1'b0;
            n_ser_on      = 1'b0;
            n_ser_stop    = 1'b0;
            n_store       = '0;
            n_digits_seen = '0;
            n_ovf         = 1'b0;
        end

        // result from the updated state; zeros unless a match was locked
        n_out_data = '0;
        if (n_locked) begin
            n_out_data = {n_ovf, n_store, n_digits_seen, n_ser_on, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= bamsp_pkg::PH_LEN;
            r_bytes_left  <= '0;
            r_cand        <= 1'b0;
            r_locked      <= 1'b0;
            r_pend_t      <= 1'b0;
            r_ser_on      <= 1'b0;
            r_ser_stop    <= 1'b0;
            r_store       <= '0;
            r_digits_seen <= '0;
            r_ovf         <= 1'b0;
        end else if (s_acc) begin
            if (i_s_tlast) begin
                // end of payload: clear for the next one
                r_phase       <= bamsp_pkg::PH_LEN;
                r_bytes_left  <= '0;
                r_cand        <= 1'b0;
                r_locked      <= 1'b0;
                r_pend_t      <= 1'b0;
                r_ser_on      <= 1'b0;
                r_ser_stop    <= 1'b0;
                r_store       <= '0;
                r_digits_seen <= '0;
                r_ovf         <= 1'b0;
            end else begin
                r_phase       <= n_phase;
                r_bytes_left  <= n_bytes_left;
                r_cand        <= n_cand;
                r_locked      <= n_locked;
                r_pend_t      <= n_pend_t;
                r_ser_on      <= n_ser_on;
                r_ser_stop    <= n_ser_stop;
                r_store       <= n_store;
                r_digits_seen <= n_digits_seen;
                r_ovf         <= n_ovf;
            end
        end
    end

    // Output register: load on the last byte, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_acc && i_s_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && i_s_tlast) begin
            r_out_data <= n_out_data;
        end
    end

    // Assertions
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data[0]) |-> (r_out_data[bamsp_pkg::M_DATA_W-1:1] == '0))
        else $error("result fields set without a match");

    a_digit_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digits_seen <= bamsp_pkg::CNT_W'(MAX_DIGITS))
        else $error("digit count above limit");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_digits_seen == bamsp_pkg::CNT_W'(MAX_DIGITS)))
        else $error("overflow before the digit store is full");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tlast) |=> (r_phase == bamsp_pkg::PH_LEN && !r_locked && r_out_valid))
        else $error("parse state not cleared after last byte");

endmodule

// ===== test/tb_ble_adv_mfr_serial_parser_core.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_ble_adv_mfr_serial_parser_core: serial scanner regression bench
// Drives advertising payloads into the byte stream. A cycle-free copy of the
// parse rules predicts one result per payload. Every result request is
// compared field by field. The company ID is rewritten between phases, and
// the two stream sides idle and stall in several patterns.
// ---------------------------------------------------------------------------
module tb_ble_adv_mfr_serial_parser_core;

    localparam int unsigned ITEMS_PER_PHASE = 130;
    localparam int unsigned N_PHASES        = 8;
    localparam int unsigned HOLD_CYCLES     = 64;
    localparam int unsigned N_DIR_ROWS      = 26;
    localparam logic [bamsp_pkg::APB_ADDR_W-1:0] ADDR_COMPANY_ID =
        {bamsp_pkg::REG_COMPANY_ID, 2'b00};

    // One result request, laid out exactly as o_m_tdata (found in bit 0).
    typedef struct packed {
        logic                         ovf;
        logic [bamsp_pkg::BCD_W-1:0]  bcd;
        logic [bamsp_pkg::CNT_W-1:0]  cnt;
        logic                         started;
        logic                         found;
    } t_serial_result;

    // One row of the directed table: a byte, its tlast, and optionally a
    // result typed in by hand in place of the predicted one.
    typedef struct packed {
        logic [7:0]     b;
        logic           last;
        logic           fixed;
        t_serial_result res;
    } t_dir_row;

    localparam t_serial_result NO_MATCH    = '0;
    localparam t_serial_result MATCH_EMPTY = '{1'b0, 64'h0, 5'd0, 1'b0, 1'b1};
    localparam t_serial_result MATCH_190   = '{1'b0, 64'h190, 5'd3, 1'b1, 1'b1};
    localparam logic [7:0]     CID_LO      = bamsp_pkg::COMPANY_ID_RESET[7:0];
    localparam logic [7:0]     CID_HI      = bamsp_pkg::COMPANY_ID_RESET[15:8];

    // ------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------
    logic                              i_clk      = 1'b0;
    logic                              i_rst_n    = 1'b0;
    logic                              i_s_tvalid = 1'b0;
    wire                               o_s_tready;
    logic [bamsp_pkg::S_DATA_W-1:0]    i_s_tdata  = '0;
    logic                              i_s_tlast  = 1'b0;
    wire                               o_m_tvalid;
    logic                              i_m_tready = 1'b0;
    wire  [bamsp_pkg::M_DATA_W-1:0]    o_m_tdata;
    logic                              psel       = 1'b0;
    logic                              penable    = 1'b0;
    logic                              pwrite     = 1'b0;
    logic [bamsp_pkg::APB_ADDR_W-1:0]  paddr      = '0;
    logic [bamsp_pkg::APB_DATA_W-1:0]  pwdata     = '0;
    wire  [bamsp_pkg::APB_DATA_W-1:0]  prdata;
    wire                               pready;

    ble_adv_mfr_serial_parser_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the parse registers
    // ------------------------------------------------------------------
    logic [15:0]                    cid_now;
    logic [2:0]                     scan_phase;
    logic [7:0]                     struct_left;
    logic                           cand;
    logic                           locked;
    logic                           saw_t;
    logic                           grab_on;
    logic                           grab_stopped;
    logic [bamsp_pkg::BCD_W-1:0]    bcd_acc;
    logic [bamsp_pkg::CNT_W-1:0]    digit_cnt;
    logic                           ovf_seen;

    t_serial_result     serial_expected [$];
    logic [7:0]         payload [$];
    int unsigned        mismatch_count = 0;

    // Idling knobs, set by the stimulus process per phase.
    int unsigned        send_idle_pct  = 0;
    int unsigned        recv_stall_pct = 0;
    // Long receiver hold-off: the stimulus bumps hold_seq, the receiver
    // process notices and counts the stretch down on its own.
    int unsigned        hold_seq  = 0;
    int unsigned        hold_seen = 0;
    int unsigned        hold_left = 0;

    t_dir_row dir_rows [N_DIR_ROWS] = '{
        // single-byte payloads: zero and all-ones, nothing can match
        '{8'h00, 1'b1, 1'b1, NO_MATCH},
        '{8'hFF, 1'b1, 1'b1, NO_MATCH},
        // zero-length entry skipped, then a matching field with no data bytes
        '{8'h00, 1'b0, 1'b0, NO_MATCH},
        '{8'h03, 1'b0, 1'b0, NO_MATCH},
        '{bamsp_pkg::AD_TYPE_MFR, 1'b0, 1'b0, NO_MATCH},
        '{CID_LO, 1'b0, 1'b0, NO_MATCH},
        '{CID_HI, 1'b1, 1'b1, MATCH_EMPTY},
        // manufacturer type with too short a length is never a candidate
        '{8'h02, 1'b0, 1'b0, NO_MATCH},
        '{bamsp_pkg::AD_TYPE_MFR, 1'b0, 1'b0, NO_MATCH},
        '{CID_LO, 1'b1, 1'b1, NO_MATCH},
        // payload ends before the field does
        '{8'h05, 1'b0, 1'b0, NO_MATCH},
        '{bamsp_pkg::AD_TYPE_MFR, 1'b0, 1'b0, NO_MATCH},
        '{CID_LO, 1'b0, 1'b0, NO_MATCH},
        '{CID_HI, 1'b0, 1'b0, NO_MATCH},
        '{bamsp_pkg::CH_T, 1'b1, 1'b1, NO_MATCH},
        // full serial "TN1#90", then a trailing byte the block must ignore
        '{8'h09, 1'b0, 1'b0, NO_MATCH},
        '{bamsp_pkg::AD_TYPE_MFR, 1'b0, 1'b0, NO_MATCH},
        '{CID_LO, 1'b0, 1'b0, NO_MATCH},
        '{CID_HI, 1'b0, 1'b0, NO_MATCH},
        '{bamsp_pkg::CH_T, 1'b0, 1'b0, NO_MATCH},
        '{bamsp_pkg::CH_N, 1'b0, 1'b0, NO_MATCH},
        '{bamsp_pkg::CH_ZERO + 8'd1, 1'b0, 1'b0, NO_MATCH},
        '{bamsp_pkg::CH_HASH, 1'b0, 1'b0, NO_MATCH},
        '{bamsp_pkg::CH_NINE, 1'b0, 1'b0, NO_MATCH},
        '{bamsp_pkg::CH_ZERO, 1'b0, 1'b0, NO_MATCH},
        '{8'h41, 1'b1, 1'b1, MATCH_190}
    };

    // Drop all per-payload state; the company ID survives.
    task automatic clear_scan();
        scan_phase   = bamsp_pkg::PH_LEN;
        struct_left  = '0;
        cand         = 1'b0;
        locked       = 1'b0;
        saw_t        = 1'b0;
        grab_on      = 1'b0;
        grab_stopped = 1'b0;
        bcd_acc      = '0;
        digit_cnt    = '0;
        ovf_seen     = 1'b0;
    endtask

    // Advance the scanner by one accepted byte. made goes high on a last
    // byte, with the result it carries.
    task automatic advance_parser(input logic [7:0] b, input logic last,
                                  output t_serial_result res, output logic made);
        res  = '0;
        made = 1'b0;
        case (scan_phase)
            bamsp_pkg::PH_LEN: begin
                // zero-length entries are skipped outright
                if (b != 8'h00) begin
                    struct_left = b;
                    scan_phase  = bamsp_pkg::PH_TYPE;
                end
            end
            bamsp_pkg::PH_TYPE: begin
                struct_left = struct_left - 8'd1;
                if (b == bamsp_pkg::AD_TYPE_MFR && struct_left >= 8'd2) begin
                    cand       = 1'b1;
                    scan_phase = bamsp_pkg::PH_CID0;
                end else begin
                    cand       = 1'b0;
                    scan_phase = (struct_left == 8'd0) ? bamsp_pkg::PH_LEN
                                                       : bamsp_pkg::PH_SKIP;
                end
            end
            bamsp_pkg::PH_CID0: begin
                struct_left = struct_left - 8'd1;
                cand        = cand && (b == cid_now[7:0]);
                scan_phase  = bamsp_pkg::PH_CID1;
            end
            bamsp_pkg::PH_CID1: begin
                struct_left = struct_left - 8'd1;
                cand        = cand && (b == cid_now[15:8]);
                if (cand) begin
                    // restart serial capture for this field
                    saw_t        = 1'b0;
                    grab_on      = 1'b0;
                    grab_stopped = 1'b0;
                    bcd_acc      = '0;
                    digit_cnt    = '0;
                    ovf_seen     = 1'b0;
                    if (struct_left == 8'd0) begin
                        locked     = 1'b1;
                        scan_phase = bamsp_pkg::PH_DONE;
                    end else begin
                        scan_phase = bamsp_pkg::PH_DATA;
                    end
                end else begin
                    scan_phase = (struct_left == 8'd0) ? bamsp_pkg::PH_LEN
                                                       : bamsp_pkg::PH_SKIP;
                end
            end
            bamsp_pkg::PH_DATA: begin
                struct_left = struct_left - 8'd1;
                if (!grab_stopped) begin
                    if (!grab_on) begin
                        // hunt for 'T' immediately followed by 'N'
                        if (saw_t && b == bamsp_pkg::CH_N) begin
                            grab_on = 1'b1;
                            saw_t   = 1'b0;
                        end else begin
                            saw_t = (b == bamsp_pkg::CH_T);
                        end
                    end else if (b >= bamsp_pkg::CH_ZERO && b <= bamsp_pkg::CH_NINE) begin
                        if (digit_cnt < bamsp_pkg::MAX_DIGITS_DEF) begin
                            bcd_acc   = {bcd_acc[bamsp_pkg::BCD_W-5:0],
                                         4'(b - bamsp_pkg::CH_ZERO)};
                            digit_cnt = digit_cnt + 5'd1;
                        end else begin
                            ovf_seen = 1'b1;
                        end
                    end else if (b != bamsp_pkg::CH_SPACE && b != bamsp_pkg::CH_HASH
                                 && b != bamsp_pkg::CH_DASH) begin
                        grab_stopped = 1'b1;
                    end
                end
                if (struct_left == 8'd0) begin
                    locked     = 1'b1;
                    scan_phase = bamsp_pkg::PH_DONE;
                end
            end
            bamsp_pkg::PH_SKIP: begin
                struct_left = struct_left - 8'd1;
                if (struct_left == 8'd0)
                    scan_phase = bamsp_pkg::PH_LEN;
            end
            default: begin
                // matched: ignore the rest of the payload
            end
        endcase
        if (last) begin
            made = 1'b1;
            if (locked)
                res = '{ovf_seen, bcd_acc, digit_cnt, grab_on, 1'b1};
            clear_scan();
        end
    endtask

    // Offer one byte, hold it until accepted, then predict.
    task automatic push_byte(input logic [7:0] b, input logic last,
                             input logic use_fixed, input t_serial_result fixed);
        t_serial_result res;
        logic           made;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        advance_parser(b, last, res, made);
        if (made)
            serial_expected.push_back(use_fixed ? fixed : res);
    endtask

    // Lower valid and wait until every result has come out, then let the
    // output stage settle before going on.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (serial_expected.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup phase, then access phase; pready is always high.
    task automatic write_company_id(input logic [15:0] id);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_COMPANY_ID;
        pwdata  <= {16'($urandom), id};   // upper bits are not part of the register
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cid_now  = id;
    endtask

    // Bias random bytes toward the characters the scanner reacts to.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return bamsp_pkg::CH_T;
            1:       return bamsp_pkg::CH_N;
            2:       return bamsp_pkg::CH_ZERO + 8'($urandom_range(9));
            3:       return bamsp_pkg::CH_DASH;
            4:       return 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Build one payload: mostly well-formed structures with a good chance of
    // a matching field, some pure noise, and now and then a cut-off tail.
    task automatic build_payload();
        int unsigned sel;
        int unsigned sep;
        logic        with_tn;
        logic [7:0]  body [$];
        payload.delete();
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 24)) payload.push_back(pick_byte());
        end else begin
            repeat ($urandom_range(1, 3)) begin
                sel = $urandom_range(99);
                body.delete();
                if (sel < 12) begin
                    payload.push_back(8'h00);
                end else if (sel < 30) begin
                    // some other AD type
                    body.push_back(8'($urandom_range(254)));
                    repeat ($urandom_range(0, 5)) body.push_back(pick_byte());
                end else if (sel < 38) begin
                    // manufacturer type too short to hold a company ID
                    body.push_back(bamsp_pkg::AD_TYPE_MFR);
                    if ($urandom_range(1) == 1)
                        body.push_back(pick_byte());
                end else if (sel < 48) begin
                    // manufacturer field of some other company
                    body.push_back(bamsp_pkg::AD_TYPE_MFR);
                    if ($urandom_range(1) == 1) begin
                        body.push_back(cid_now[7:0] ^ 8'($urandom_range(1, 255)));
                        body.push_back(cid_now[15:8]);
                    end else begin
                        body.push_back(cid_now[7:0]);
                        body.push_back(cid_now[15:8] ^ 8'($urandom_range(1, 255)));
                    end
                    repeat ($urandom_range(0, 4)) body.push_back(pick_byte());
                end else begin
                    // matching field with serial text
                    body.push_back(bamsp_pkg::AD_TYPE_MFR);
                    body.push_back(cid_now[7:0]);
                    body.push_back(cid_now[15:8]);
                    repeat ($urandom_range(0, 2)) body.push_back(pick_byte());
                    with_tn = ($urandom_range(99) < 85);
                    if (with_tn) begin
                        body.push_back(bamsp_pkg::CH_T);
                        body.push_back(bamsp_pkg::CH_N);
                    end
                    repeat ($urandom_range(0, 20)) begin
                        if ($urandom_range(99) < 20) begin
                            sep = $urandom_range(2);
                            body.push_back(sep == 0 ? bamsp_pkg::CH_SPACE :
                                           (sep == 1 ? bamsp_pkg::CH_HASH
                                                     : bamsp_pkg::CH_DASH));
                        end
                        body.push_back(bamsp_pkg::CH_ZERO + 8'($urandom_range(9)));
                    end
                    if ($urandom_range(99) < 50)
                        body.push_back(pick_byte());
                    // a lone 'T' at the very end must not start the serial
                    if ($urandom_range(99) < (with_tn ? 10 : 50))
                        body.push_back(bamsp_pkg::CH_T);
                end
                if (body.size() != 0) begin
                    payload.push_back(8'(body.size()));
                    foreach (body[k]) payload.push_back(body[k]);
                end
            end
            // cut the payload short somewhere inside
            if ($urandom_range(99) < 12 && payload.size() > 1)
                repeat ($urandom_range(1, payload.size() - 1)) void'(payload.pop_back());
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, long hold-off, and result checking
    // ------------------------------------------------------------------
    task automatic check_result(input t_serial_result got);
        t_serial_result want;
        if (serial_expected.size() == 0) begin
            $display("%0t: result with none pending: expected none, actual %h", $time, got);
            mismatch_count++;
        end else begin
            want = serial_expected.pop_front();
            if (got.found !== want.found)
                $display("%0t: found: expected %0d, actual %0d", $time, want.found, got.found);
            if (got.started !== want.started)
                $display("%0t: serial_started: expected %0d, actual %0d",
                         $time, want.started, got.started);
            if (got.cnt !== want.cnt)
                $display("%0t: digit_count: expected %0d, actual %0d", $time, want.cnt, got.cnt);
            if (got.bcd !== want.bcd)
                $display("%0t: serial_bcd: expected %h, actual %h", $time, want.bcd, got.bcd);
            if (got.ovf !== want.ovf)
                $display("%0t: digits_overflow: expected %0d, actual %0d",
                         $time, want.ovf, got.ovf);
            if (got !== want)
                mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            check_result(o_m_tdata);
        // load a fresh hold-off when asked, else count the current one down
        if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        i_m_tready <= (hold_left == 0) && (hold_seen == hold_seq)
                      && ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] phase_ids [N_PHASES];
        int unsigned phase_items;
        cid_now = bamsp_pkg::COMPANY_ID_RESET;
        clear_scan();
        phase_ids = '{16'hFFFF, 16'h0000, 16'($urandom), bamsp_pkg::COMPANY_ID_RESET,
                      16'($urandom), 16'h00FF, 16'hFF00, 16'($urandom)};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, run against the reset company ID, no idling.
        for (int r = 0; r < N_DIR_ROWS; r++)
            push_byte(dir_rows[r].b, dir_rows[r].last, dir_rows[r].fixed, dir_rows[r].res);

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            write_company_id(phase_ids[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            phase_items = 0;
            if (p == 0) begin
                // Hold the receiver off while single-byte payloads keep
                // coming, so the output stage fills and input request stalls.
                hold_seq = hold_seq + 1;
                repeat (12) begin
                    push_byte(8'($urandom_range(255)), 1'b1, 1'b0, NO_MATCH);
                    phase_items++;
                end
                // pause the sender until every result has drained
                drain_results();
            end
            while (phase_items < ITEMS_PER_PHASE) begin
                build_payload();
                foreach (payload[k])
                    push_byte(payload[k], k == payload.size() - 1, 1'b0, NO_MATCH);
                phase_items += payload.size();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ble_adv_mfr_serial_parser_core regression: pass");
        end else begin
            $display("ble_adv_mfr_serial_parser_core regression: fail");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #4000000;
        $display("ble_adv_mfr_serial_parser_core regression: fail");
        $finish;
    end

endmodule
